// File: rtl/dflt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dflt_pkg: shared constants for the deduplicating fault log
// Field widths, opcodes, configuration indexes and reset values.
// ----------------------------------------------------------------------------
package dflt_pkg;

    // Default table depths
    localparam int CODE_ENTRIES_DEF  = 16;
    localparam int FAULT_ENTRIES_DEF = 16;

    // Field widths
    localparam int CODE_W   = 16;
    localparam int STAMP_W  = 32;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W = 2;

    // Transaction opcodes
    localparam logic [OP_W-1:0] OP_STORE_CODE  = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE_FAULT = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK        = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_CODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_FAULT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERNAL_CODE = 2'd2;

    // Configuration reset values
    localparam logic [CODE_W-1:0] RST_EMPTY_CODE    = 16'd0;
    localparam logic [CODE_W-1:0] RST_EMPTY_FAULT   = 16'd0;
    localparam logic [CODE_W-1:0] RST_INTERNAL_CODE = 16'd1;

    // Value an unwritten slot reads as (empty marker at reset)
    localparam logic [CODE_W-1:0] SLOT_RESET_CODE = 16'd0;

    // Result table kinds
    localparam logic KIND_FAULT = 1'b0;
    localparam logic KIND_CODE  = 1'b1;

endpackage : dflt_pkg
`default_nettype wire

// File: rtl/dflt_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dflt_table: one log table
// Synchronous memory of code/timestamp entries with one read and one write
// port and registered read data. Per-entry valid flags make unwritten slots
// read as the reset code.
// ----------------------------------------------------------------------------
module dflt_table
    import dflt_pkg::*;
#(
    parameter int ENTRIES = CODE_ENTRIES_DEF,
    localparam int AW = $clog2(ENTRIES)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [AW-1:0]      i_rd_addr,
    output logic      [CODE_W-1:0]  o_rd_code,
    output logic      [STAMP_W-1:0] o_rd_time,
    input  wire logic               i_we,
    input  wire logic [AW-1:0]      i_wr_addr,
    input  wire logic [CODE_W-1:0]  i_wr_code,
    input  wire logic [STAMP_W-1:0] i_wr_time
);

    logic [CODE_W-1:0]  r_code_mem [ENTRIES];
    logic [STAMP_W-1:0] r_time_mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [CODE_W-1:0]  r_rd_code;
    logic [STAMP_W-1:0] r_rd_time;
    logic               r_rd_valid;

    // Write and read the storage array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_code_mem[i_wr_addr] <= i_wr_code;
            r_time_mem[i_wr_addr] <= i_wr_time;
        end
        r_rd_code <= r_code_mem[i_rd_addr];
        r_rd_time <= r_time_mem[i_rd_addr];
    end

    // Track written entries; reset marks all slots empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    // Substitute the reset code for unwritten entries
    assign o_rd_code = r_rd_valid ? r_rd_code : SLOT_RESET_CODE;
    assign o_rd_time = r_rd_time;

endmodule : dflt_table
`default_nettype wire

// File: rtl/dedup_fault_log_table.sv
`default_nettype none
// Store-code does one memory read per slot, then at most one write.
// Store-fault scans the fault table, then for a new fault also stores the internal code; a repeated fault stops there.
// Tick gives zero, one or two results; results leave on o_result_valid.
// One transaction at a time: busy stays high until it completes.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset (synchronous, active low) empties both tables and zeroes both pointers.
// ----------------------------------------------------------------------------
// dedup_fault_log_table: deduplicating two-table fault log
// Sequencer that scans the table memories for duplicates and free slots,
// writes new entries, and reads out one entry per table on each tick.
// ----------------------------------------------------------------------------
module dedup_fault_log_table
    import dflt_pkg::*;
#(
    parameter int CODE_ENTRIES  = CODE_ENTRIES_DEF,
    parameter int FAULT_ENTRIES = FAULT_ENTRIES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [OP_W-1:0]      i_opcode,
    input  wire logic [CODE_W-1:0]    i_code,
    input  wire logic [STAMP_W-1:0]   i_stamp_ms,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CODE_W-1:0]    i_cfg_wdata,
    output logic                      o_result_valid,
    output logic                      o_table_kind,
    output logic      [CODE_W-1:0]    o_entry_code,
    output logic      [STAMP_W-1:0]   o_entry_time,
    output logic                      o_last_of_run
);

    localparam int CAW = $clog2(CODE_ENTRIES);
    localparam int FAW = $clog2(FAULT_ENTRIES);
    localparam int IW  = (CAW > FAW) ? CAW : FAW;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_SCAN      = 7'b0000010,
        S_LAST      = 7'b0000100,
        S_WRITE     = 7'b0001000,
        S_TICK      = 7'b0010000,
        S_TICK_DATA = 7'b0100000,
        S_EMIT_C    = 7'b1000000
    } t_state;

    t_state             r_state, n_state;
    logic [CODE_W-1:0]  r_empty_code, r_empty_fault, r_ifc;
    logic               r_sel, n_sel;            // 1: code table, 0: fault table
    logic               r_chain, n_chain;        // follow with internal code store
    logic [CODE_W-1:0]  r_key, n_key;
    logic [STAMP_W-1:0] r_stamp, n_stamp;
    logic [IW-1:0]      r_idx, n_idx;
    logic [IW-1:0]      r_pend_idx;
    logic               r_pend;
    logic               r_dup, n_dup;
    logic               r_free_found, n_free_found;
    logic [IW-1:0]      r_free_idx, n_free_idx;
    logic [CAW-1:0]     r_cptr, n_cptr;
    logic [FAW-1:0]     r_fptr, n_fptr;
    logic [CODE_W-1:0]  r_c_code, n_c_code;
    logic [STAMP_W-1:0] r_c_time, n_c_time;
    logic               r_out_valid, n_out_valid;
    logic               r_out_kind, n_out_kind;
    logic [CODE_W-1:0]  r_out_code, n_out_code;
    logic [STAMP_W-1:0] r_out_time, n_out_time;
    logic               r_out_last, n_out_last;

    logic [CAW-1:0]     code_rd_addr;
    logic [FAW-1:0]     fault_rd_addr;
    logic [CODE_W-1:0]  code_rd_code, fault_rd_code;
    logic [STAMP_W-1:0] code_rd_time, fault_rd_time;
    logic               code_we, fault_we;
    logic [CODE_W-1:0]  scan_code, scan_marker;
    logic [IW-1:0]      scan_last;
    logic               f_hit, c_hit;

    // Table memories
    dflt_table #(.ENTRIES(CODE_ENTRIES)) u_code_tbl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (code_rd_addr),
        .o_rd_code (code_rd_code),
        .o_rd_time (code_rd_time),
        .i_we      (code_we),
        .i_wr_addr (r_free_idx[CAW-1:0]),
        .i_wr_code (r_key),
        .i_wr_time (r_stamp)
    );

    dflt_table #(.ENTRIES(FAULT_ENTRIES)) u_fault_tbl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (fault_rd_addr),
        .o_rd_code (fault_rd_code),
        .o_rd_time (fault_rd_time),
        .i_we      (fault_we),
        .i_wr_addr (r_free_idx[FAW-1:0]),
        .i_wr_code (r_key),
        .i_wr_time (r_stamp)
    );

    // Address the tables: pointers on a tick, scan index otherwise
    assign code_rd_addr  = (r_state == S_TICK) ? r_cptr : r_idx[CAW-1:0];
    assign fault_rd_addr = (r_state == S_TICK) ? r_fptr : r_idx[FAW-1:0];

    // Write a new entry once the scan found no duplicate and a free slot
    assign code_we  = (r_state == S_WRITE) && r_sel && !r_dup && r_free_found;
    assign fault_we = (r_state == S_WRITE) && !r_sel && !r_dup && r_free_found;

    // Select the table under scan
    assign scan_code   = r_sel ? code_rd_code : fault_rd_code;
    assign scan_marker = r_sel ? r_empty_code : r_empty_fault;
    assign scan_last   = r_sel ? IW'(CODE_ENTRIES - 1) : IW'(FAULT_ENTRIES - 1);

    assign f_hit = (fault_rd_code != r_empty_fault);
    assign c_hit = (code_rd_code != r_empty_code);

    // Sequence the transaction
    always_comb begin
        n_state      = r_state;
        n_sel        = r_sel;
        n_chain      = r_chain;
        n_key        = r_key;
        n_stamp      = r_stamp;
        n_idx        = r_idx;
        n_dup        = r_dup;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_cptr       = r_cptr;
        n_fptr       = r_fptr;
        n_c_code     = r_c_code;
        n_c_time     = r_c_time;
        n_out_valid  = 1'b0;
        n_out_kind   = r_out_kind;
        n_out_code   = r_out_code;
        n_out_time   = r_out_time;
        n_out_last   = r_out_last;

        // Check the slot read in the previous cycle
        if (r_pend) begin
            if (scan_code == r_key) begin
                n_dup = 1'b1;
            end
            if ((scan_code == scan_marker) && !r_free_found) begin
                n_free_found = 1'b1;
                n_free_idx   = r_pend_idx;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_key        = i_code;
                    n_stamp      = i_stamp_ms;
                    n_idx        = '0;
                    n_dup        = 1'b0;
                    n_free_found = 1'b0;
                    case (i_opcode)
                        OP_STORE_CODE: begin
                            n_sel   = 1'b1;
                            n_chain = 1'b0;
                            n_state = S_SCAN;
                        end
                        OP_STORE_FAULT: begin
                            n_sel   = 1'b0;
                            n_chain = 1'b1;
                            n_state = S_SCAN;
                        end
                        OP_TICK: begin
                            n_state = S_TICK;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_idx = r_idx + IW'(1);
                if (r_idx == scan_last) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                // A new fault also logs the internal trouble code
                if (r_chain && !r_dup) begin
                    n_sel        = 1'b1;
                    n_chain      = 1'b0;
                    n_key        = r_ifc;
                    n_idx        = '0;
                    n_dup        = 1'b0;
                    n_free_found = 1'b0;
                    n_state      = S_SCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_TICK: begin
                n_cptr  = (r_cptr == CAW'(CODE_ENTRIES - 1)) ? '0 : r_cptr + CAW'(1);
                n_fptr  = (r_fptr == FAW'(FAULT_ENTRIES - 1)) ? '0 : r_fptr + FAW'(1);
                n_state = S_TICK_DATA;
            end
            S_TICK_DATA: begin
                n_c_code = code_rd_code;
                n_c_time = code_rd_time;
                n_state  = S_IDLE;
                if (f_hit) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_FAULT;
                    n_out_code  = fault_rd_code;
                    n_out_time  = fault_rd_time;
                    n_out_last  = !c_hit;
                    if (c_hit) begin
                        n_state = S_EMIT_C;
                    end
                end else if (c_hit) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_CODE;
                    n_out_code  = code_rd_code;
                    n_out_time  = code_rd_time;
                    n_out_last  = 1'b1;
                end
            end
            S_EMIT_C: begin
                n_out_valid = 1'b1;
                n_out_kind  = KIND_CODE;
                n_out_code  = r_c_code;
                n_out_time  = r_c_time;
                n_out_last  = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_cptr      <= '0;
            r_fptr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= (r_state == S_SCAN);
            r_cptr      <= n_cptr;
            r_fptr      <= n_fptr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and scan bookkeeping
    always_ff @(posedge i_clk) begin
        r_sel        <= n_sel;
        r_chain      <= n_chain;
        r_key        <= n_key;
        r_stamp      <= n_stamp;
        r_idx        <= n_idx;
        r_pend_idx   <= r_idx;
        r_dup        <= n_dup;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_c_code     <= n_c_code;
        r_c_time     <= n_c_time;
        r_out_kind   <= n_out_kind;
        r_out_code   <= n_out_code;
        r_out_time   <= n_out_time;
        r_out_last   <= n_out_last;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_code  <= RST_EMPTY_CODE;
            r_empty_fault <= RST_EMPTY_FAULT;
            r_ifc         <= RST_INTERNAL_CODE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EMPTY_CODE:    r_empty_code  <= i_cfg_wdata;
                CFG_EMPTY_FAULT:   r_empty_fault <= i_cfg_wdata;
                CFG_INTERNAL_CODE: r_ifc         <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_table_kind   = r_out_kind;
    assign o_entry_code   = r_out_code;
    assign o_entry_time   = r_out_time;
    assign o_last_of_run  = r_out_last;

    // Never write both tables in one cycle
    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(code_we && fault_we))
        else $error("both tables written in one cycle");

    // A result that is not the last is followed by the code-table result
    a_second_is_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_last_of_run) |=> (o_result_valid && o_table_kind))
        else $error("first tick result not followed by code entry");

    // Results come only out of a tick readout
    a_result_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(r_state) == S_TICK_DATA || $past(r_state) == S_EMIT_C))
        else $error("result outside tick readout");

    // An accepted tick keeps the block busy in the next cycle
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_opcode == OP_TICK) |=> busy)
        else $error("tick accepted but block not busy");

endmodule : dedup_fault_log_table
`default_nettype wire
